[rtl/rpn_stack_calculator_assert.svh]
// Assertion macros shared by the calculator RTL.
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RPN_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RPN_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Expression must never be true.
`define RPN_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

[rtl/rpn_pkg.sv]
// Shared types, codes and helper functions of the RPN calculator.
package rpn_pkg;

  localparam int WORD_W   = 32;
  localparam int REQ_W    = 3;
  localparam int STATUS_W = 3;
  localparam int DEPTH_W  = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SUB  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_MUL  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DIV  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_PUSHED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_COMPUTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FEW      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DIVZERO  = 3'd4;

  localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [1:0] {ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV} alu_op_t;

  typedef struct packed {
    logic              start;
    alu_op_t           op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [WORD_W-1:0] result;
  } alu_rsp_t;

  typedef struct packed {
    logic              push;
    logic              reduce;
    logic              rd_lower;
    logic [WORD_W-1:0] wr_data;
  } stk_ctrl_t;

  typedef struct packed {
    logic               full;
    logic               few;
    logic [DEPTH_W-1:0] depth;
  } stk_stat_t;

  // Returns {sat, word} for a sign and a 33-bit magnitude; ovf marks bits lost above it.
  function automatic logic [WORD_W:0] clamp_mag(input logic neg, input logic ovf,
                                                input logic [WORD_W:0] mag);
    logic [WORD_W:0] r;
    if (!neg) begin
      if (ovf || (mag > {1'b0, SAT_POS})) r = {1'b1, SAT_POS};
      else r = {1'b0, mag[WORD_W-1:0]};
    end else begin
      if (ovf || (mag > {1'b0, SAT_NEG})) r = {1'b1, SAT_NEG};
      else r = {1'b0, (~mag[WORD_W-1:0]) + 32'd1};
    end
    return r;
  endfunction

  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v);
    return v[WORD_W-1] ? (~v) + 32'd1 : v;
  endfunction

endpackage

[rtl/rpn_if.sv]
// Request and response channel interfaces of the RPN calculator.
interface rpn_req_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] operand_value;

  modport source (output valid, output req_type, output operand_value, input ready);
  modport sink   (input valid, input req_type, input operand_value, output ready);
endinterface

interface rpn_rsp_if import rpn_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [WORD_W-1:0] result_value;
  logic                     saturated;
  logic [DEPTH_W-1:0]       stack_depth;

  modport source (output valid, output status, output result_value, output saturated,
                  output stack_depth, input ready);
  modport sink   (input valid, input status, input result_value, input saturated,
                  input stack_depth, output ready);
endinterface

[rtl/rpn_stack.sv]
// Operand stack memory with its stack pointer.
`include "rpn_stack_calculator_assert.svh"

module rpn_stack import rpn_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  stk_ctrl_t         ctrl,
  output logic [WORD_W-1:0] rd_data,
  output stk_stat_t         stat
);

  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int AW  = $clog2(STACK_DEPTH);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rd_data_r;
  logic [SPW-1:0]    sp_r;
  logic [SPW-1:0]    sp_nxt;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr;

  // A reduce overwrites the lower operand, which sits two below the pointer.
  assign wr_addr = ctrl.push ? AW'(sp_r) : AW'(sp_r - SPW'(2));
  assign rd_addr = ctrl.rd_lower ? AW'(sp_r - SPW'(2)) : AW'(sp_r - SPW'(1));

  always_comb begin
    sp_nxt = sp_r;
    if (ctrl.push) sp_nxt = sp_r + SPW'(1);
    else if (ctrl.reduce) sp_nxt = sp_r - SPW'(1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.reduce) mem[wr_addr] <= ctrl.wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sp_r <= '0;
    else sp_r <= sp_nxt;
  end

  assign rd_data    = rd_data_r;
  assign stat.full  = (sp_r == SPW'(STACK_DEPTH));
  assign stat.few   = (sp_r < SPW'(2));
  assign stat.depth = DEPTH_W'(sp_r);

  `RPN_ASSERT_NEVER(a_sp_range, sp_r > SPW'(STACK_DEPTH), "stack pointer beyond depth")
  `RPN_ASSERT_NEVER(a_push_reduce, ctrl.push && ctrl.reduce, "push and reduce together")
  `RPN_ASSERT_NEXT(a_push_grows, ctrl.push, sp_r == $past(sp_r) + SPW'(1), "push lost")

endmodule

[rtl/rpn_alu.sv]
// Bit-serial arithmetic unit: serial add/subtract, shift-add multiply, restoring divide.
`include "rpn_stack_calculator_assert.svh"

module rpn_alu import rpn_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  input  alu_cmd_t cmd,
  output alu_rsp_t rsp
);

  localparam int DIV_STEPS = WORD_W + FRACTION_BITS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  typedef enum logic [1:0] {A_IDLE, A_RUN, A_DONE} alu_state_t;

  alu_state_t        state_r, state_nxt;
  alu_op_t           op_r, op_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [WORD_W-1:0] x_r, x_nxt;
  logic [WORD_W-1:0] y_r, y_nxt;
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W:0]   q_r, q_nxt;
  logic              carry_r, carry_nxt;
  logic              ovf_r, ovf_nxt;
  logic              neg_r, neg_nxt;
  logic              xs_r, xs_nxt;
  logic              ys_r, ys_nxt;
  logic              done_r, done_nxt;
  logic              sat_r, sat_nxt;
  logic [WORD_W-1:0] res_r, res_nxt;

  logic              sum_bit;
  logic [WORD_W:0]   mul_sum;
  logic [WORD_W:0]   div_shift;
  logic              div_ge;
  logic [WORD_W:0]   div_diff;
  logic [2*WORD_W-1:0] prod_scaled;
  logic              top_bit;
  logic [WORD_W:0]   clamped;

  always_comb begin
    sum_bit     = x_r[0] ^ y_r[0] ^ carry_r;
    mul_sum     = {1'b0, acc_r} + (x_r[0] ? {1'b0, y_r} : '0);
    div_shift   = {acc_r, x_r[WORD_W-1]};
    div_ge      = (div_shift >= {1'b0, y_r});
    div_diff    = div_shift - {1'b0, y_r};
    prod_scaled = {acc_r, x_r} >> FRACTION_BITS;
    top_bit     = xs_r ^ ys_r ^ carry_r;
    clamped     = '0;

    state_nxt = state_r;
    op_nxt    = op_r;
    cnt_nxt   = cnt_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    acc_nxt   = acc_r;
    q_nxt     = q_r;
    carry_nxt = carry_r;
    ovf_nxt   = ovf_r;
    neg_nxt   = neg_r;
    xs_nxt    = xs_r;
    ys_nxt    = ys_r;
    done_nxt  = 1'b0;
    sat_nxt   = sat_r;
    res_nxt   = res_r;

    unique case (state_r)
      A_IDLE: begin
        if (cmd.start) begin
          state_nxt = A_RUN;
          op_nxt    = cmd.op;
          acc_nxt   = '0;
          q_nxt     = '0;
          ovf_nxt   = 1'b0;
          neg_nxt   = cmd.a[WORD_W-1] ^ cmd.b[WORD_W-1];
          cnt_nxt   = CNT_W'(WORD_W);
          case (cmd.op)
            ALU_ADD: begin
              x_nxt     = cmd.a;
              y_nxt     = cmd.b;
              carry_nxt = 1'b0;
              xs_nxt    = cmd.a[WORD_W-1];
              ys_nxt    = cmd.b[WORD_W-1];
            end
            ALU_SUB: begin
              // Subtract as add of the inverted operand with a carry in.
              x_nxt     = cmd.a;
              y_nxt     = ~cmd.b;
              carry_nxt = 1'b1;
              xs_nxt    = cmd.a[WORD_W-1];
              ys_nxt    = ~cmd.b[WORD_W-1];
            end
            ALU_MUL: begin
              x_nxt = magnitude(cmd.a);
              y_nxt = magnitude(cmd.b);
            end
            default: begin
              x_nxt   = magnitude(cmd.a);
              y_nxt   = magnitude(cmd.b);
              cnt_nxt = CNT_W'(DIV_STEPS);
            end
          endcase
        end
      end
      A_RUN: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) state_nxt = A_DONE;
        case (op_r)
          ALU_ADD, ALU_SUB: begin
            acc_nxt   = {sum_bit, acc_r[WORD_W-1:1]};
            carry_nxt = (x_r[0] & y_r[0]) | (carry_r & (x_r[0] ^ y_r[0]));
            x_nxt     = x_r >> 1;
            y_nxt     = y_r >> 1;
          end
          ALU_MUL: begin
            acc_nxt = mul_sum[WORD_W:1];
            x_nxt   = {mul_sum[0], x_r[WORD_W-1:1]};
          end
          default: begin
            // The remainder stays below the divisor, so 32 bits hold it.
            acc_nxt = div_ge ? div_diff[WORD_W-1:0] : div_shift[WORD_W-1:0];
            x_nxt   = x_r << 1;
            q_nxt   = {q_r[WORD_W-1:0], div_ge};
            ovf_nxt = ovf_r | q_r[WORD_W];
          end
        endcase
      end
      A_DONE: begin
        case (op_r)
          ALU_ADD, ALU_SUB: begin
            if (top_bit != acc_r[WORD_W-1]) clamped = {1'b1, top_bit ? SAT_NEG : SAT_POS};
            else clamped = {1'b0, acc_r};
          end
          ALU_MUL: begin
            clamped = clamp_mag(neg_r, |prod_scaled[2*WORD_W-1:WORD_W],
                                {1'b0, prod_scaled[WORD_W-1:0]});
          end
          default: clamped = clamp_mag(neg_r, ovf_r, q_r);
        endcase
        sat_nxt   = clamped[WORD_W];
        res_nxt   = clamped[WORD_W-1:0];
        done_nxt  = 1'b1;
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
    op_r    <= op_nxt;
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    acc_r   <= acc_nxt;
    q_r     <= q_nxt;
    carry_r <= carry_nxt;
    ovf_r   <= ovf_nxt;
    neg_r   <= neg_nxt;
    xs_r    <= xs_nxt;
    ys_r    <= ys_nxt;
    sat_r   <= sat_nxt;
    res_r   <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.sat    = sat_r;
  assign rsp.result = res_r;

  `RPN_ASSERT_IMPL(a_start_idle, cmd.start, state_r == A_IDLE, "start while busy")
  `RPN_ASSERT_IMPL(a_run_count, state_r == A_RUN, cnt_r != '0, "step counter empty in run")

endmodule

[rtl/rpn_stack_calculator.sv]
// A push or a rejected item goes from acceptance straight to S_FIN; an operator reads its
// operands in S_RD_B and S_RD_A, runs the bit-serial unit in S_ALU (skipped on divide by zero)
// and then enters S_FIN. The bit-serial unit works one bit per cycle: 32 steps, 32 + FRACTION_BITS to divide.
// S_FIN loads the result into the output register once that register is free. One item is in
// work at a time; the next can be accepted in the cycle after the result enters the output register.
// Synchronous active-low reset empties the stack; stack contents are not cleared.
`include "rpn_stack_calculator_assert.svh"

module rpn_stack_calculator import rpn_pkg::*; #(
  parameter int STACK_DEPTH   = 16,
  parameter int FRACTION_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  rpn_req_if.sink   in_req,
  rpn_rsp_if.source out_rsp
);

  typedef enum logic [2:0] {S_IDLE, S_RD_B, S_RD_A, S_ALU, S_FIN} top_state_t;

  top_state_t          state_r, state_nxt;
  alu_op_t             op_r, op_nxt;
  logic [WORD_W-1:0]   b_r, b_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [WORD_W-1:0]   result_r, result_nxt;
  logic                sat_r, sat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [WORD_W-1:0]   out_result_r, out_result_nxt;
  logic                out_sat_r, out_sat_nxt;
  logic [DEPTH_W-1:0]  out_depth_r, out_depth_nxt;

  logic              accept;
  logic              out_free;
  stk_ctrl_t         stk_ctrl;
  stk_stat_t         stk_stat;
  logic [WORD_W-1:0] stk_rd_data;
  alu_cmd_t          alu_cmd;
  alu_rsp_t          alu_rsp;

  rpn_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (stk_ctrl),
    .rd_data (stk_rd_data),
    .stat    (stk_stat)
  );

  rpn_alu #(.FRACTION_BITS(FRACTION_BITS)) u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (alu_cmd),
    .rsp   (alu_rsp)
  );

  assign in_req.ready = (state_r == S_IDLE);
  assign accept       = in_req.valid && in_req.ready;
  assign out_free     = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    b_nxt          = b_r;
    status_nxt     = status_r;
    result_nxt     = result_r;
    sat_nxt        = sat_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_result_nxt = out_result_r;
    out_sat_nxt    = out_sat_r;
    out_depth_nxt  = out_depth_r;

    stk_ctrl          = '0;
    stk_ctrl.rd_lower = (state_r == S_RD_B);
    stk_ctrl.wr_data  = (state_r == S_ALU) ? alu_rsp.result : WORD_W'(in_req.operand_value);

    alu_cmd       = '0;
    alu_cmd.op    = op_r;
    alu_cmd.a     = stk_rd_data;
    alu_cmd.b     = b_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          result_nxt = '0;
          sat_nxt    = 1'b0;
          state_nxt  = S_FIN;
          unique case (in_req.req_type)
            REQ_ADD: op_nxt = ALU_ADD;
            REQ_SUB: op_nxt = ALU_SUB;
            REQ_MUL: op_nxt = ALU_MUL;
            REQ_DIV: op_nxt = ALU_DIV;
            default: op_nxt = ALU_ADD;
          endcase
          // Unused request codes behave as a push.
          if (in_req.req_type inside {REQ_ADD, REQ_SUB, REQ_MUL, REQ_DIV}) begin
            if (stk_stat.few) status_nxt = ST_FEW;
            else state_nxt = S_RD_B;
          end else if (stk_stat.full) begin
            status_nxt = ST_FULL;
          end else begin
            stk_ctrl.push = 1'b1;
            status_nxt    = ST_PUSHED;
          end
        end
      end
      S_RD_B: begin
        b_nxt     = stk_rd_data;
        state_nxt = S_RD_A;
      end
      S_RD_A: begin
        if (op_r == ALU_DIV && b_r == '0) begin
          status_nxt = ST_DIVZERO;
          state_nxt  = S_FIN;
        end else begin
          alu_cmd.start = 1'b1;
          state_nxt     = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          stk_ctrl.reduce = 1'b1;
          status_nxt      = ST_COMPUTED;
          result_nxt      = alu_rsp.result;
          sat_nxt         = alu_rsp.sat;
          state_nxt       = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_result_nxt = result_r;
          out_sat_nxt    = sat_r;
          out_depth_nxt  = stk_stat.depth;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    b_r          <= b_nxt;
    status_r     <= status_nxt;
    result_r     <= result_nxt;
    sat_r        <= sat_nxt;
    out_status_r <= out_status_nxt;
    out_result_r <= out_result_nxt;
    out_sat_r    <= out_sat_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_rsp.valid        = out_valid_r;
  assign out_rsp.status       = out_status_r;
  assign out_rsp.result_value = out_result_r;
  assign out_rsp.saturated    = out_sat_r;
  assign out_rsp.stack_depth  = out_depth_r;

  `RPN_ASSERT_IMPL(a_done_in_alu, alu_rsp.done, state_r == S_ALU, "unit done out of turn")
  `RPN_ASSERT_NEXT(a_fin_loads, state_r == S_FIN && out_free, out_valid_r && state_r == S_IDLE, "result beat not loaded")

endmodule

[test/tb_rpn_stack_calculator.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the RPN stack calculator with random request and result stalls.
module tb_rpn_stack_calculator;
  import rpn_pkg::*;

  localparam int STACK_SLOTS  = 16;
  localparam int FRAC_BITS    = 16;
  localparam int RANDOM_ITEMS = 615;
  localparam int PHASE_LEN    = 30;
  localparam int HOLD_AT      = 200;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 60;

  // Request codes above divide are treated as pushes.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]  code;
    logic [WORD_W-1:0] value;
    logic              wait_drain;
  } calc_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   value;
    logic                sat;
    logic [DEPTH_W-1:0]  depth;
  } calc_answer_t;

  logic clk;
  logic rst_n;

  rpn_req_if req_bus ();
  rpn_rsp_if rsp_bus ();

  rpn_stack_calculator #(
    .STACK_DEPTH  (STACK_SLOTS),
    .FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_bus),
    .out_rsp(rsp_bus)
  );

  calc_req_t    pending_reqs[$];
  calc_answer_t awaited_answers[$];

  logic [WORD_W-1:0] calc_stack [STACK_SLOTS];
  int unsigned       calc_sp;

  int unsigned items_taken;
  int unsigned answers_seen;
  int unsigned planned_total;
  int unsigned fail_count;
  int unsigned sat_count;
  int unsigned status_hits [8];
  int unsigned send_gap;
  int unsigned send_calm;
  int unsigned recv_stall;
  int unsigned recv_calm;
  int unsigned hold_left;
  logic        long_hold_done;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Returns {saturated, word} for a sign and a magnitude.
  function automatic logic [WORD_W:0] saturate(logic neg, logic [63:0] mag);
    if (!neg) return (mag > 64'h7FFF_FFFF) ? {1'b1, SAT_POS} : {1'b0, mag[WORD_W-1:0]};
    return (mag > 64'h8000_0000) ? {1'b1, SAT_NEG} : {1'b0, ~mag[WORD_W-1:0] + 32'd1};
  endfunction

  // Applies one request to the shadow stack and returns the answer it produces.
  function automatic calc_answer_t rpn_eval(logic [REQ_W-1:0] code, logic [WORD_W-1:0] value);
    calc_answer_t     ans;
    logic signed [63:0] lhs;
    logic signed [63:0] rhs;
    logic signed [63:0] wide;
    logic [63:0]        mag_l;
    logic [63:0]        mag_r;
    logic [WORD_W:0]    word;
    ans = '0;
    if (code == REQ_ADD || code == REQ_SUB || code == REQ_MUL || code == REQ_DIV) begin
      if (calc_sp < 2) begin
        ans.status = ST_FEW;
      end else begin
        lhs = $signed(calc_stack[calc_sp-2]);
        rhs = $signed(calc_stack[calc_sp-1]);
        mag_l = (lhs < 0) ? -lhs : lhs;
        mag_r = (rhs < 0) ? -rhs : rhs;
        word = '0;
        case (code)
          REQ_ADD, REQ_SUB: begin
            wide = (code == REQ_ADD) ? lhs + rhs : lhs - rhs;
            word = saturate(wide < 0, (wide < 0) ? -wide : wide);
          end
          REQ_MUL: begin
            wide = lhs * rhs;
            word = saturate(wide < 0, ((wide < 0) ? -wide : wide) >> FRAC_BITS);
          end
          default: begin
            if (rhs != 0) word = saturate((lhs < 0) != (rhs < 0), (mag_l << FRAC_BITS) / mag_r);
          end
        endcase
        if (code == REQ_DIV && rhs == 0) begin
          ans.status = ST_DIVZERO;
        end else begin
          calc_stack[calc_sp-2] = word[WORD_W-1:0];
          calc_sp--;
          ans.status = ST_COMPUTED;
          ans.value  = word[WORD_W-1:0];
          ans.sat    = word[WORD_W];
        end
      end
    end else if (calc_sp >= STACK_SLOTS) begin
      ans.status = ST_FULL;
    end else begin
      calc_stack[calc_sp] = value;
      calc_sp++;
      ans.status = ST_PUSHED;
    end
    ans.depth = calc_sp[DEPTH_W-1:0];
    return ans;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Mixes the interesting Q16.16 values with small and fully random ones.
  function automatic logic [WORD_W-1:0] pick_operand();
    case ($urandom_range(7))
      0: return '0;
      1: return SAT_POS;
      2: return SAT_NEG;
      3: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      4, 5: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  task automatic add_req(logic [REQ_W-1:0] code, logic [WORD_W-1:0] value, logic drain);
    calc_req_t item;
    item.code = code;
    item.value = value;
    item.wait_drain = drain;
    pending_reqs.push_back(item);
  endtask

  task automatic note_mismatch(string field, logic [WORD_W-1:0] want_v, logic [WORD_W-1:0] got_v);
    $display("%0t: %s mismatch on result %0d, expected %h, got %h",
             $time, field, answers_seen, want_v, got_v);
    fail_count++;
  endtask

  // Driver: one beat per request, with random gaps and an optional drain before a request.
  always @(posedge clk) begin
    calc_req_t item;
    logic      free;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      req_bus.req_type <= REQ_PUSH;
      req_bus.operand_value <= '0;
    end else begin
      free = !req_bus.valid;
      if (req_bus.valid && req_bus.ready) begin
        awaited_answers.push_back(rpn_eval(req_bus.req_type, req_bus.operand_value));
        items_taken++;
        free = 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = pick_gap();
          if ($urandom_range(39) == 0) send_calm = $urandom_range(60, 20);
        end
      end
      if (free) begin
        if (send_gap > 0 || pending_reqs.size() == 0 ||
            (pending_reqs[0].wait_drain && items_taken != answers_seen)) begin
          if (send_gap > 0) send_gap--;
          req_bus.valid <= 1'b0;
        end else begin
          item = pending_reqs.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.req_type <= item.code;
          req_bus.operand_value <= item.value;
        end
      end
    end
  end

  // Monitor: checks each result beat and throttles ready.
  always @(posedge clk) begin
    calc_answer_t want;
    logic         go;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      go = 1'b1;
      if (rsp_bus.valid && rsp_bus.ready) begin
        answers_seen <= answers_seen + 1;
        if (awaited_answers.size() == 0) begin
          $display("%0t: unexpected result, expected none, got status %0d value %h depth %0d",
                   $time, rsp_bus.status, rsp_bus.result_value, rsp_bus.stack_depth);
          fail_count++;
        end else begin
          want = awaited_answers.pop_front();
          status_hits[want.status]++;
          if (want.sat) sat_count++;
          if (rsp_bus.status !== want.status)
            note_mismatch("status", want.status, rsp_bus.status);
          if (rsp_bus.result_value !== want.value)
            note_mismatch("result_value", want.value, rsp_bus.result_value);
          if (rsp_bus.saturated !== want.sat)
            note_mismatch("saturated", want.sat, rsp_bus.saturated);
          if (rsp_bus.stack_depth !== want.depth)
            note_mismatch("stack_depth", want.depth, rsp_bus.stack_depth);
        end
        if (!long_hold_done && answers_seen + 1 == HOLD_AT) begin
          // Hold off long enough for the block to back up into the request side.
          hold_left = LONG_HOLD;
          long_hold_done = 1'b1;
        end else if (recv_calm > 0) begin
          recv_calm--;
        end else begin
          recv_stall = pick_gap();
          if ($urandom_range(39) == 0) recv_calm = $urandom_range(60, 20);
        end
      end else if (recv_calm == 0 && recv_stall == 0 && $urandom_range(15) == 0) begin
        recv_stall = $urandom_range(4, 1);
      end
      if (hold_left > 0) begin
        hold_left--;
        go = 1'b0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        go = 1'b0;
      end
      rsp_bus.ready <= go;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int unsigned push_pct;
    calc_req_t   item;
    rst_n = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = REQ_PUSH;
    req_bus.operand_value = '0;
    rsp_bus.ready = 1'b0;
    calc_sp = 0;
    items_taken = 0;
    answers_seen = 0;
    fail_count = 0;
    sat_count = 0;
    send_gap = 0;
    send_calm = 0;
    recv_stall = 0;
    recv_calm = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    idle_cycles = 0;
    push_pct = 50;
    foreach (status_hits[i]) status_hits[i] = 0;

    // Directed: too few operands, clamping both ways, divide by zero, spare codes,
    // truncation toward zero, then a full stack.
    add_req(REQ_ADD, 32'hDEAD_BEEF, 1'b0);
    add_req(REQ_PUSH, SAT_POS, 1'b0);
    add_req(REQ_MUL, '0, 1'b0);
    add_req(REQ_PUSH, SAT_POS, 1'b0);
    add_req(REQ_ADD, '0, 1'b0);
    add_req(REQ_PUSH, SAT_NEG, 1'b0);
    add_req(REQ_SUB, '0, 1'b0);
    add_req(REQ_PUSH, SAT_NEG, 1'b0);
    add_req(REQ_PUSH, SAT_NEG, 1'b0);
    add_req(REQ_ADD, '0, 1'b0);
    add_req(REQ_MUL, '0, 1'b0);
    add_req(REQ_SPARE_LO, 32'hFFFF_0000, 1'b0);
    add_req(REQ_DIV, '0, 1'b0);
    add_req(REQ_PUSH, '0, 1'b0);
    add_req(REQ_DIV, 32'hFFFF_FFFF, 1'b0);
    add_req(REQ_SPARE_LO + 3'd1, 32'hFFFE_8000, 1'b0);
    add_req(REQ_SPARE_HI, 32'h0000_0003, 1'b0);
    add_req(REQ_MUL, '0, 1'b0);
    add_req(REQ_PUSH, 32'h0003_0000, 1'b0);
    add_req(REQ_DIV, '0, 1'b0);
    for (int k = 0; k < 13; k++) add_req(REQ_PUSH, $urandom(), 1'b0);
    add_req(REQ_PUSH, 32'h1234_5678, 1'b0);
    add_req(REQ_ADD, '0, 1'b0);

    // Random: phases of push-heavy, balanced and pop-heavy traffic sweep the depth range.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(2))
          0: push_pct = 85;
          1: push_pct = 55;
          default: push_pct = 25;
        endcase
      end
      item.wait_drain = (n % 150 == 0);
      if ($urandom_range(99) < push_pct) begin
        item.code = ($urandom_range(9) == 0) ?
                    REQ_W'($urandom_range(REQ_SPARE_HI, REQ_SPARE_LO)) : REQ_PUSH;
        item.value = pick_operand();
      end else begin
        item.code = REQ_W'($urandom_range(REQ_DIV, REQ_ADD));
        item.value = $urandom();
      end
      pending_reqs.push_back(item);
    end
    planned_total = pending_reqs.size();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (answers_seen != planned_total) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (awaited_answers.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_answers.size());
      fail_count++;
    end

    $display("Run covered %0d requests and %0d results, %0d of them clamped.",
             items_taken, answers_seen, sat_count);
    $display("Statuses seen: pushed %0d, computed %0d, too few %0d, full %0d, div by zero %0d.",
             status_hits[ST_PUSHED], status_hits[ST_COMPUTED], status_hits[ST_FEW],
             status_hits[ST_FULL], status_hits[ST_DIVZERO]);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
